// File: rtl/cxalu_pkg.sv
// Package for the complex ALU with magnitude.
// Holds the operation codes and the default word and fraction widths.
`timescale 1ns / 1ps

package cxalu_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 28;

  typedef enum logic [1:0] {
    FN_ADD  = 2'd0,
    FN_SUB  = 2'd1,
    FN_MUL  = 2'd2,
    FN_PASS = 2'd3
  } func_t;

endpackage

// File: rtl/cxalu_arith.sv
// Complex add, subtract, multiply and pass, in three register stages:
// operate and multiply, combine and scale, saturate. Uses cxalu_pkg.
`timescale 1ns / 1ps

module cxalu_arith
  import cxalu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  func_t                func,
  input  logic [WORD_BITS-1:0] a_re,
  input  logic [WORD_BITS-1:0] a_im,
  input  logic [WORD_BITS-1:0] b_re,
  input  logic [WORD_BITS-1:0] b_im,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] res_re,
  output logic [WORD_BITS-1:0] res_im,
  output logic                 overflow
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;

  // stage 1
  logic                 v1;
  func_t                fn1;
  logic signed [W:0]    sum_re, sum_im;
  logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir;
  // stage 2
  logic                 v2;
  logic signed [XW-1:0] val_re, val_im;
  // stage 3
  logic                 v3;

  logic en1, en2, en3;
  logic signed [W:0]     sum_re_next, sum_im_next;
  logic signed [XW-1:0]  wre, wim, val_re_next, val_im_next;
  logic                  ok_re, ok_im;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    case (func)
      FN_SUB: begin
        sum_re_next = $signed({a_re[W-1], a_re}) - $signed({b_re[W-1], b_re});
        sum_im_next = $signed({a_im[W-1], a_im}) - $signed({b_im[W-1], b_im});
      end
      FN_ADD: begin
        sum_re_next = $signed({a_re[W-1], a_re}) + $signed({b_re[W-1], b_re});
        sum_im_next = $signed({a_im[W-1], a_im}) + $signed({b_im[W-1], b_im});
      end
      default: begin
        sum_re_next = $signed({a_re[W-1], a_re});
        sum_im_next = $signed({a_im[W-1], a_im});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      fn1    <= func;
      sum_re <= sum_re_next;
      sum_im <= sum_im_next;
      p_rr   <= PW'($signed(a_re)) * PW'($signed(b_re));
      p_ii   <= PW'($signed(a_im)) * PW'($signed(b_im));
      p_ri   <= PW'($signed(a_re)) * PW'($signed(b_im));
      p_ir   <= PW'($signed(a_im)) * PW'($signed(b_re));
    end
  end

  always_comb begin
    wre = XW'(p_rr) - XW'(p_ii);
    wim = XW'(p_ri) + XW'(p_ir);
    if (fn1 == FN_MUL) begin
      val_re_next = wre >>> FRAC_BITS;
      val_im_next = wim >>> FRAC_BITS;
    end else begin
      val_re_next = XW'(sum_re);
      val_im_next = XW'(sum_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      val_re <= val_re_next;
      val_im <= val_im_next;
    end
  end

  // in range when the bits from the word sign up are all equal
  assign ok_re = (&val_re[XW-1:W-1]) || !(|val_re[XW-1:W-1]);
  assign ok_im = (&val_im[XW-1:W-1]) || !(|val_im[XW-1:W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3 && v2) begin
      res_re   <= ok_re ? val_re[W-1:0] : {val_re[XW-1], {(W-1){!val_re[XW-1]}}};
      res_im   <= ok_im ? val_im[W-1:0] : {val_im[XW-1], {(W-1){!val_im[XW-1]}}};
      overflow <= !(ok_re && ok_im);
    end
  end

  assign out_valid = v3;

endmodule

// File: rtl/cxalu_sumsq.sv
// Sum of squares of the saturated result parts, two register stages:
// square, then add. Carries the result parts along. Uses cxalu_pkg.
`timescale 1ns / 1ps

module cxalu_sumsq
  import cxalu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [WORD_BITS-1:0]   in_re,
  input  logic [WORD_BITS-1:0]   in_im,
  input  logic                   in_ovf,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_BITS-1:0]   out_re,
  output logic [WORD_BITS-1:0]   out_im,
  output logic                   out_ovf,
  output logic [2*WORD_BITS-1:0] sumsq
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;

  logic                  v1, v2;
  logic signed [2*W-1:0] sq_re, sq_im;
  logic [W-1:0]          re1, im1;
  logic                  ovf1;
  logic                  en1, en2;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      sq_re <= PW'($signed(in_re)) * PW'($signed(in_re));
      sq_im <= PW'($signed(in_im)) * PW'($signed(in_im));
      re1   <= in_re;
      im1   <= in_im;
      ovf1  <= in_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      sumsq   <= unsigned'(sq_re) + unsigned'(sq_im);
      out_re  <= re1;
      out_im  <= im1;
      out_ovf <= ovf1;
    end
  end

  assign out_valid = v2;

endmodule

// File: rtl/cxalu_sqrt_step.sv
// One register stage of the digit-by-digit integer square root:
// takes two radicand bits and settles one root bit. Uses cxalu_pkg.
`timescale 1ns / 1ps

module cxalu_sqrt_step
  import cxalu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2*WORD_BITS-1:0] in_rad,
  input  logic [WORD_BITS+1:0]   in_rem,
  input  logic [WORD_BITS-1:0]   in_root,
  input  logic [WORD_BITS-1:0]   in_re,
  input  logic [WORD_BITS-1:0]   in_im,
  input  logic                   in_ovf,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2*WORD_BITS-1:0] out_rad,
  output logic [WORD_BITS+1:0]   out_rem,
  output logic [WORD_BITS-1:0]   out_root,
  output logic [WORD_BITS-1:0]   out_re,
  output logic [WORD_BITS-1:0]   out_im,
  output logic                   out_ovf
);

  localparam int W = WORD_BITS;

  logic         v;
  logic [W+3:0] rem_sh, trial, rem_next;
  logic         ge;

  assign rem_sh   = {in_rem, in_rad[2*W-1 -: 2]};
  assign trial    = {2'b00, in_root, 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_next = ge ? rem_sh - trial : rem_sh;

  assign in_ready = !v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_rad  <= {in_rad[2*W-3:0], 2'b00};
      out_rem  <= rem_next[W+1:0];
      out_root <= {in_root[W-2:0], ge};
      out_re   <= in_re;
      out_im   <= in_im;
      out_ovf  <= in_ovf;
    end
  end

  assign out_valid = v;

endmodule

// File: rtl/complex_alu_with_magnitude.sv
// Stages: three arithmetic, two sum-of-squares, and one per root bit.
// Throughput: one item per cycle; every stage holds when the next is full.
// Reset: rst clears all stage valid bits; data registers are not reset.
// Uses cxalu_pkg, cxalu_arith, cxalu_sumsq and cxalu_sqrt_step.
`timescale 1ns / 1ps

module complex_alu_with_magnitude
  import cxalu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int IN_BITS  = ((4 * WORD_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_BITS = ((3 * WORD_BITS + 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // func, a_re, a_im, b_re, b_im
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // res_re, res_im, magnitude, overflow
  output logic [OUT_BITS-1:0] m_axis_tdata
);

  localparam int W = WORD_BITS;

  logic         ar_valid, ar_ready;
  logic [W-1:0] ar_re, ar_im;
  logic         ar_ovf;

  logic           sq_valid;
  logic [W-1:0]   sq_re, sq_im;
  logic           sq_ovf;
  logic [2*W-1:0] sq_sum;

  logic           st_valid [W+1];
  logic           st_ready [W+1];
  logic [2*W-1:0] st_rad   [W+1];
  logic [W+1:0]   st_rem   [W+1];
  logic [W-1:0]   st_root  [W+1];
  logic [W-1:0]   st_re    [W+1];
  logic [W-1:0]   st_im    [W+1];
  logic           st_ovf   [W+1];

  cxalu_arith #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .func      (func_t'(s_axis_tdata[1:0])),
    .a_re      (s_axis_tdata[2 +: W]),
    .a_im      (s_axis_tdata[2 + W +: W]),
    .b_re      (s_axis_tdata[2 + 2*W +: W]),
    .b_im      (s_axis_tdata[2 + 3*W +: W]),
    .out_valid (ar_valid),
    .out_ready (ar_ready),
    .res_re    (ar_re),
    .res_im    (ar_im),
    .overflow  (ar_ovf)
  );

  cxalu_sumsq #(
    .WORD_BITS (WORD_BITS)
  ) u_sumsq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ar_valid),
    .in_ready  (ar_ready),
    .in_re     (ar_re),
    .in_im     (ar_im),
    .in_ovf    (ar_ovf),
    .out_valid (sq_valid),
    .out_ready (st_ready[0]),
    .out_re    (sq_re),
    .out_im    (sq_im),
    .out_ovf   (sq_ovf),
    .sumsq     (sq_sum)
  );

  assign st_valid[0] = sq_valid;
  assign st_rad[0]   = sq_sum;
  assign st_rem[0]   = '0;
  assign st_root[0]  = '0;
  assign st_re[0]    = sq_re;
  assign st_im[0]    = sq_im;
  assign st_ovf[0]   = sq_ovf;

  for (genvar k = 0; k < W; k++) begin : g_root
    cxalu_sqrt_step #(
      .WORD_BITS (WORD_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_rad    (st_rad[k]),
      .in_rem    (st_rem[k]),
      .in_root   (st_root[k]),
      .in_re     (st_re[k]),
      .in_im     (st_im[k]),
      .in_ovf    (st_ovf[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_rad   (st_rad[k+1]),
      .out_rem   (st_rem[k+1]),
      .out_root  (st_root[k+1]),
      .out_re    (st_re[k+1]),
      .out_im    (st_im[k+1]),
      .out_ovf   (st_ovf[k+1])
    );
  end

  assign st_ready[W]   = m_axis_tready;
  assign m_axis_tvalid = st_valid[W];
  assign m_axis_tdata  = OUT_BITS'({st_ovf[W], st_root[W], st_im[W], st_re[W]});

endmodule

// File: rtl/cxalu_checker.sv
// Port-level checks for complex_alu_with_magnitude, bound to the top level.
// Uses cxalu_pkg for the default word width.
`timescale 1ns / 1ps

module cxalu_checker
  import cxalu_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int OUT_BITS = ((3 * WORD_BITS + 1 + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  localparam int W = WORD_BITS;

  logic signed [W-1:0] re, im;
  logic [W-1:0]        mag;
  logic                ovf;
  logic [W-1:0]        abs_re, abs_im;
  logic [W-1:0]        max_pos, min_neg;

  assign re      = m_axis_tdata[W-1:0];
  assign im      = m_axis_tdata[2*W-1:W];
  assign mag     = m_axis_tdata[3*W-1:2*W];
  assign ovf     = m_axis_tdata[3*W];
  assign abs_re  = re[W-1] ? W'(-re) : W'(re);
  assign abs_im  = im[W-1] ? W'(-im) : W'(im);
  assign max_pos = {1'b0, {(W-1){1'b1}}};
  assign min_neg = {1'b1, {(W-1){1'b0}}};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ovf |-> re == max_pos || re == min_neg ||
                             im == max_pos || im == min_neg)
    else $error("overflow set without a saturated part");

  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> mag >= abs_re && mag >= abs_im)
    else $error("magnitude below a part's absolute value");

endmodule

bind complex_alu_with_magnitude cxalu_checker #(
  .WORD_BITS (WORD_BITS)
) u_cxalu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
